/* rtl/core/spi_master_byte_transfer_defines.svh */
// Assertion macros used by the back end of the SPI master byte transfer RTL.
`ifndef SPI_MASTER_BYTE_TRANSFER_DEFINES_SVH
`define SPI_MASTER_BYTE_TRANSFER_DEFINES_SVH

`ifndef SYNTH

// Same-cycle implication, disabled while reset is held.
`define SMBT_ASSERT_IMP(lbl, clk, rst_n, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, disabled while reset is held.
`define SMBT_ASSERT_NXT(lbl, clk, rst_n, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`else

`define SMBT_ASSERT_IMP(lbl, clk, rst_n, ante, cons, msg)
`define SMBT_ASSERT_NXT(lbl, clk, rst_n, ante, cons, msg)

`endif

`endif

/* rtl/core/smbt_pkg.sv */
// Shared constants and types of the SPI master byte transfer block.
`timescale 1ns / 1ps

package smbt_pkg;

  localparam int MAX_BYTES = 1024;
  localparam int ADDR_W    = (MAX_BYTES > 1) ? $clog2(MAX_BYTES) : 1;
  localparam int CNT_W     = $clog2(MAX_BYTES + 1);

  typedef enum logic [1:0] {
    PH_IDLE  = 2'd0,
    PH_SETUP = 2'd1,
    PH_SEND  = 2'd2,
    PH_END   = 2'd3
  } phase_t;

  typedef enum logic {
    KIND_LOAD = 1'b0,
    KIND_TICK = 1'b1
  } kind_t;

  typedef enum logic {
    BK_FETCH = 1'b0,
    BK_EXEC  = 1'b1
  } back_state_t;

  typedef struct packed {
    kind_t      kind;
    logic [7:0] tx_byte;
    logic       load_last;
    logic       miso;
  } item_t;

  typedef struct packed {
    logic  valid;
    item_t item;
  } q_head_t;

endpackage

/* rtl/core/smbt_ram.sv */
// Generic single-write, single-read RAM with a registered read port.
`timescale 1ns / 1ps

module smbt_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 1024,
  localparam int AW   = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic             clk,
  input  logic             wr_en,
  input  logic [AW-1:0]    wr_addr,
  input  logic [WIDTH-1:0] wr_data,
  input  logic             rd_en,
  input  logic [AW-1:0]    rd_addr,
  output logic [WIDTH-1:0] rd_data
);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [WIDTH-1:0] rd_data_r;

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    if (rd_en) begin
      rd_data_r <= mem[rd_addr];
    end
  end

  assign rd_data = rd_data_r;

endmodule

/* rtl/core/smbt_front.sv */
// Input side: accepts words, decodes the operation and queues them for the back end.
`timescale 1ns / 1ps

module smbt_front
  import smbt_pkg::*;
(
  input  logic       clk,
  input  logic       rst_n,
  input  logic       in_valid,
  output logic       in_ready,
  input  logic       in_op,
  input  logic [7:0] in_tx_byte,
  input  logic       in_load_last,
  input  logic       in_miso,
  output q_head_t    q_head,
  input  logic       q_pop
);

  item_t      q_mem_r [2];
  logic       wr_ptr_r, wr_ptr_nxt;
  logic       rd_ptr_r, rd_ptr_nxt;
  logic [1:0] count_r, count_nxt;
  logic       push;
  item_t      in_item;

  assign in_ready = (count_r != 2'd2);
  assign push     = in_valid && in_ready;

  always_comb begin
    in_item.kind      = in_op ? KIND_TICK : KIND_LOAD;
    in_item.tx_byte   = in_tx_byte;
    in_item.load_last = in_load_last;
    in_item.miso      = in_miso;
  end

  always_comb begin
    wr_ptr_nxt = push ? ~wr_ptr_r : wr_ptr_r;
    rd_ptr_nxt = q_pop ? ~rd_ptr_r : rd_ptr_r;
    count_nxt  = count_r + {1'b0, push} - {1'b0, q_pop};
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= 1'b0;
      rd_ptr_r <= 1'b0;
      count_r  <= 2'd0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      count_r  <= count_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      q_mem_r[wr_ptr_r] <= in_item;
    end
  end

  assign q_head.valid = (count_r != 2'd0);
  assign q_head.item  = q_mem_r[rd_ptr_r];

endmodule

/* rtl/core/smbt_back.sv */
// Execution side: transfer state, transmit store and the result register.
`timescale 1ns / 1ps

`include "spi_master_byte_transfer_defines.svh"

module smbt_back
  import smbt_pkg::*;
(
  input  logic       clk,
  input  logic       rst_n,
  input  q_head_t    q_head,
  output logic       q_pop,
  output logic       out_valid,
  input  logic       out_ready,
  output logic       out_chip_select,
  output logic       out_serial_clock,
  output logic       out_mosi,
  output logic       out_rx_valid,
  output logic [7:0] out_rx_byte,
  output logic       out_rx_last,
  output logic       out_busy_res
);

  back_state_t       bk_state_r, bk_state_nxt;
  item_t             cur_r, cur_nxt;
  phase_t            phase_r, phase_nxt;
  logic [CNT_W-1:0]  load_count_r, load_count_nxt;
  logic              msg_ready_r, msg_ready_nxt;
  logic              clock_half_r, clock_half_nxt;
  logic [2:0]        bit_count_r, bit_count_nxt;
  logic [ADDR_W-1:0] byte_index_r, byte_index_nxt;
  logic [7:0]        rx_shift_r, rx_shift_nxt;
  logic              pin_cs_r, pin_cs_nxt;
  logic              pin_clk_r, pin_clk_nxt;
  logic              pin_mosi_r, pin_mosi_nxt;

  logic              out_valid_r, out_valid_nxt;
  logic              res_rx_valid_r, res_rx_valid_nxt;
  logic [7:0]        res_rx_byte_r, res_rx_byte_nxt;
  logic              res_rx_last_r, res_rx_last_nxt;
  logic              res_busy_r, res_busy_nxt;
  logic              res_load;

  logic              wr_en;
  logic              rd_en;
  logic [7:0]        rd_data;
  logic [2:0]        bit_sel;
  logic [CNT_W-1:0]  next_index;
  logic              slot_free;

  smbt_ram #(
    .WIDTH (8),
    .DEPTH (MAX_BYTES)
  ) u_store (
    .clk     (clk),
    .wr_en   (wr_en),
    .wr_addr (load_count_r[ADDR_W-1:0]),
    .wr_data (cur_r.tx_byte),
    .rd_en   (rd_en),
    .rd_addr (byte_index_r),
    .rd_data (rd_data)
  );

  assign slot_free  = !out_valid_r || out_ready;
  assign bit_sel    = 3'd7 - bit_count_r;
  assign next_index = CNT_W'(byte_index_r) + CNT_W'(1);

  always_comb begin
    bk_state_nxt     = bk_state_r;
    cur_nxt          = cur_r;
    phase_nxt        = phase_r;
    load_count_nxt   = load_count_r;
    msg_ready_nxt    = msg_ready_r;
    clock_half_nxt   = clock_half_r;
    bit_count_nxt    = bit_count_r;
    byte_index_nxt   = byte_index_r;
    rx_shift_nxt     = rx_shift_r;
    pin_cs_nxt       = pin_cs_r;
    pin_clk_nxt      = pin_clk_r;
    pin_mosi_nxt     = pin_mosi_r;
    res_rx_valid_nxt = 1'b0;
    res_rx_byte_nxt  = 8'd0;
    res_rx_last_nxt  = 1'b0;
    res_busy_nxt     = 1'b0;
    res_load         = 1'b0;
    q_pop            = 1'b0;
    rd_en            = 1'b0;
    wr_en            = 1'b0;
    out_valid_nxt    = out_valid_r && !out_ready;

    case (bk_state_r)
      BK_FETCH: begin
        // The store read is issued here so its data is ready for the execute cycle.
        if (q_head.valid) begin
          cur_nxt      = q_head.item;
          q_pop        = 1'b1;
          rd_en        = 1'b1;
          bk_state_nxt = BK_EXEC;
        end
      end
      BK_EXEC: begin
        if (slot_free) begin
          if (cur_r.kind == KIND_LOAD) begin
            if ((phase_r inside {PH_IDLE, PH_SETUP}) && !msg_ready_r) begin
              if (load_count_r < CNT_W'(MAX_BYTES)) begin
                wr_en          = 1'b1;
                load_count_nxt = load_count_r + CNT_W'(1);
              end
              if (cur_r.load_last) begin
                msg_ready_nxt = 1'b1;
              end
            end
          end else begin
            case (phase_r)
              PH_IDLE, PH_SETUP: begin
                if (msg_ready_r) begin
                  msg_ready_nxt  = 1'b0;
                  byte_index_nxt = '0;
                  bit_count_nxt  = 3'd0;
                  clock_half_nxt = 1'b0;
                  rx_shift_nxt   = 8'd0;
                  pin_cs_nxt     = 1'b0;
                  pin_clk_nxt    = 1'b1;
                  phase_nxt      = PH_SEND;
                end
              end
              PH_SEND: begin
                pin_mosi_nxt = rd_data[bit_sel];
                if (!clock_half_r) begin
                  pin_clk_nxt    = 1'b0;
                  clock_half_nxt = 1'b1;
                end else begin
                  pin_clk_nxt    = 1'b1;
                  clock_half_nxt = 1'b0;
                  rx_shift_nxt   = {rx_shift_r[6:0], cur_r.miso};
                  if (bit_count_r == 3'd7) begin
                    bit_count_nxt    = 3'd0;
                    res_rx_valid_nxt = 1'b1;
                    res_rx_byte_nxt  = {rx_shift_r[6:0], cur_r.miso};
                    if (next_index >= load_count_r) begin
                      res_rx_last_nxt = 1'b1;
                      phase_nxt       = PH_END;
                    end else begin
                      byte_index_nxt = next_index[ADDR_W-1:0];
                    end
                  end else begin
                    bit_count_nxt = bit_count_r + 3'd1;
                  end
                end
              end
              PH_END: begin
                pin_cs_nxt     = 1'b1;
                pin_clk_nxt    = 1'b1;
                phase_nxt      = PH_IDLE;
                load_count_nxt = '0;
                msg_ready_nxt  = 1'b0;
                byte_index_nxt = '0;
                bit_count_nxt  = 3'd0;
                clock_half_nxt = 1'b0;
              end
              default: begin
              end
            endcase
          end
          res_busy_nxt  = (phase_nxt == PH_SEND) || (phase_nxt == PH_END);
          res_load      = 1'b1;
          out_valid_nxt = 1'b1;
          bk_state_nxt  = BK_FETCH;
        end
      end
      default: begin
        bk_state_nxt = BK_FETCH;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      bk_state_r   <= BK_FETCH;
      phase_r      <= PH_IDLE;
      load_count_r <= '0;
      msg_ready_r  <= 1'b0;
      clock_half_r <= 1'b0;
      bit_count_r  <= 3'd0;
      byte_index_r <= '0;
      rx_shift_r   <= 8'd0;
      pin_cs_r     <= 1'b1;
      pin_clk_r    <= 1'b1;
      pin_mosi_r   <= 1'b0;
      out_valid_r  <= 1'b0;
    end else begin
      bk_state_r   <= bk_state_nxt;
      phase_r      <= phase_nxt;
      load_count_r <= load_count_nxt;
      msg_ready_r  <= msg_ready_nxt;
      clock_half_r <= clock_half_nxt;
      bit_count_r  <= bit_count_nxt;
      byte_index_r <= byte_index_nxt;
      rx_shift_r   <= rx_shift_nxt;
      pin_cs_r     <= pin_cs_nxt;
      pin_clk_r    <= pin_clk_nxt;
      pin_mosi_r   <= pin_mosi_nxt;
      out_valid_r  <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    cur_r <= cur_nxt;
    if (res_load) begin
      res_rx_valid_r <= res_rx_valid_nxt;
      res_rx_byte_r  <= res_rx_byte_nxt;
      res_rx_last_r  <= res_rx_last_nxt;
      res_busy_r     <= res_busy_nxt;
    end
  end

  // Pin levels change only when a result word is loaded, so they match that word.
  assign out_valid        = out_valid_r;
  assign out_chip_select  = pin_cs_r;
  assign out_serial_clock = pin_clk_r;
  assign out_mosi         = pin_mosi_r;
  assign out_rx_valid     = res_rx_valid_r;
  assign out_rx_byte      = res_rx_byte_r;
  assign out_rx_last      = res_rx_last_r;
  assign out_busy_res     = res_busy_r;

  `SMBT_ASSERT_IMP(a_busy_not_ready, clk, rst_n, (phase_r == PH_SEND) || (phase_r == PH_END), !msg_ready_r, "message ready flag set during a transfer")
  `SMBT_ASSERT_IMP(a_cs_tracks_phase, clk, rst_n, 1'b1, pin_cs_r == !((phase_r == PH_SEND) || (phase_r == PH_END)), "chip select disagrees with transfer phase")
  `SMBT_ASSERT_IMP(a_index_in_range, clk, rst_n, phase_r == PH_SEND, CNT_W'(byte_index_r) < load_count_r, "byte index beyond loaded bytes")
  `SMBT_ASSERT_NXT(a_exec_follows_pop, clk, rst_n, q_pop, bk_state_r == BK_EXEC, "queue pop not followed by execute")

endmodule

/* rtl/core/spi_master_byte_transfer.sv */
// An input word leaves the two-entry queue, is fetched by the back end (which also issues
// the transmit store read) and is executed into the result register once the output is free.
// The back end fetches and executes each word in turn, so it takes no new word from the queue
// until the current one has been executed and its result word loaded.
// A two-entry queue between front and back lets input and output stall independently.
// Reset (synchronous, active low) clears all control state; pins return to select high,
// clock high, MOSI low. The transmit store holds no reset value.
`timescale 1ns / 1ps

module spi_master_byte_transfer
  import smbt_pkg::*;
(
  input  logic       clk,
  input  logic       rst_n,
  input  logic       in_valid,
  output logic       in_ready,
  input  logic       in_op,
  input  logic [7:0] in_tx_byte,
  input  logic       in_load_last,
  input  logic       in_miso,
  output logic       out_valid,
  input  logic       out_ready,
  output logic       out_chip_select,
  output logic       out_serial_clock,
  output logic       out_mosi,
  output logic       out_rx_valid,
  output logic [7:0] out_rx_byte,
  output logic       out_rx_last,
  output logic       out_busy_res
);

  q_head_t q_head;
  logic    q_pop;

  smbt_front u_front (
    .clk          (clk),
    .rst_n        (rst_n),
    .in_valid     (in_valid),
    .in_ready     (in_ready),
    .in_op        (in_op),
    .in_tx_byte   (in_tx_byte),
    .in_load_last (in_load_last),
    .in_miso      (in_miso),
    .q_head       (q_head),
    .q_pop        (q_pop)
  );

  smbt_back u_back (
    .clk              (clk),
    .rst_n            (rst_n),
    .q_head           (q_head),
    .q_pop            (q_pop),
    .out_valid        (out_valid),
    .out_ready        (out_ready),
    .out_chip_select  (out_chip_select),
    .out_serial_clock (out_serial_clock),
    .out_mosi         (out_mosi),
    .out_rx_valid     (out_rx_valid),
    .out_rx_byte      (out_rx_byte),
    .out_rx_last      (out_rx_last),
    .out_busy_res     (out_busy_res)
  );

endmodule

/* bench/spi_master_byte_transfer_tb.sv */
`timescale 1ns / 1ps
// Self-checking testbench for the mode 3 SPI master byte transfer block.
module spi_master_byte_transfer_tb
  import smbt_pkg::*;
();

  localparam int WORD_TARGET = 1900;
  localparam int STALL_LIMIT = 2000;
  localparam int HOLD_AT     = 3000;
  localparam int HOLD_LEN    = 400;
  localparam int DRAIN_WAIT  = 12;
  localparam int DIR_ROWS    = 8;

  typedef struct packed {
    logic       cs;
    logic       sclk;
    logic       mosi;
    logic       rx_valid;
    logic [7:0] rx_byte;
    logic       rx_last;
    logic       busy;
  } pin_word_t;

  typedef struct packed {
    kind_t      op;
    logic [7:0] tx_byte;
    logic       last;
    logic       miso;
    logic [4:0] reps;
    logic       typed;
    pin_word_t  want;
  } dir_row_t;

  localparam pin_word_t IDLE_PINS  = {1'b1, 1'b1, 1'b0, 1'b0, 8'h00, 1'b0, 1'b0};
  localparam pin_word_t START_PINS = {1'b0, 1'b1, 1'b0, 1'b0, 8'h00, 1'b0, 1'b1};
  localparam pin_word_t NO_PINS    = '0;

  logic       clk = 1'b0;
  logic       rst_n = 1'b0;
  logic       in_valid = 1'b0;
  logic       in_ready;
  logic       in_op = 1'b0;
  logic [7:0] in_tx_byte = 8'h00;
  logic       in_load_last = 1'b0;
  logic       in_miso = 1'b0;
  logic       out_valid;
  logic       out_ready = 1'b0;
  logic       out_chip_select;
  logic       out_serial_clock;
  logic       out_mosi;
  logic       out_rx_valid;
  logic [7:0] out_rx_byte;
  logic       out_rx_last;
  logic       out_busy_res;

  // Shadow state of the SPI master.
  logic [7:0]        tx_mem [MAX_BYTES];
  logic [CNT_W-1:0]  mem_fill  = '0;
  logic              msg_ready = 1'b0;
  phase_t            ph        = PH_IDLE;
  logic              high_next = 1'b0;
  logic [2:0]        bit_pos   = '0;
  logic [ADDR_W-1:0] byte_pos  = '0;
  logic [7:0]        rx_acc    = '0;
  logic              pin_cs    = 1'b1;
  logic              pin_sck   = 1'b1;
  logic              pin_mosi  = 1'b0;

  pin_word_t pin_exp_q [$];
  int        mismatches   = 0;
  int        words_sent   = 0;
  int        burst_left   = 1;
  int        quiet_cycles = 0;

  // A single message of one 0xFF byte, with a load ignored while the message is ready and one during the send.
  dir_row_t dir_tab [DIR_ROWS] = '{
    '{KIND_TICK, 8'h00, 1'b0, 1'b0, 5'd1,  1'b1, IDLE_PINS},
    '{KIND_LOAD, 8'hFF, 1'b1, 1'b0, 5'd1,  1'b1, IDLE_PINS},
    '{KIND_LOAD, 8'h00, 1'b0, 1'b1, 5'd1,  1'b1, IDLE_PINS},
    '{KIND_TICK, 8'h00, 1'b0, 1'b0, 5'd1,  1'b1, START_PINS},
    '{KIND_LOAD, 8'h3C, 1'b1, 1'b0, 5'd1,  1'b1, START_PINS},
    '{KIND_TICK, 8'hA5, 1'b1, 1'b1, 5'd16, 1'b0, NO_PINS},
    '{KIND_TICK, 8'h00, 1'b0, 1'b0, 5'd1,  1'b0, NO_PINS},
    '{KIND_TICK, 8'hFF, 1'b1, 1'b1, 5'd1,  1'b1, {1'b1, 1'b1, 1'b1, 1'b0, 8'h00, 1'b0, 1'b0}}
  };

  spi_master_byte_transfer dut (
    .clk              (clk),
    .rst_n            (rst_n),
    .in_valid         (in_valid),
    .in_ready         (in_ready),
    .in_op            (in_op),
    .in_tx_byte       (in_tx_byte),
    .in_load_last     (in_load_last),
    .in_miso          (in_miso),
    .out_valid        (out_valid),
    .out_ready        (out_ready),
    .out_chip_select  (out_chip_select),
    .out_serial_clock (out_serial_clock),
    .out_mosi         (out_mosi),
    .out_rx_valid     (out_rx_valid),
    .out_rx_byte      (out_rx_byte),
    .out_rx_last      (out_rx_last),
    .out_busy_res     (out_busy_res)
  );

  initial begin
    forever #5 clk = ~clk;
  end

  function automatic pin_word_t predict_pins(kind_t op, logic [7:0] txb, logic last,
                                             logic miso);
    pin_word_t  r;
    logic [7:0] cur;
    logic       idle;
    r = '0;
    idle = (ph == PH_IDLE) || (ph == PH_SETUP);
    if (op == KIND_LOAD) begin
      if (idle && !msg_ready) begin
        // A full store drops the byte, but the last flag still takes effect.
        if (int'(mem_fill) < MAX_BYTES) begin
          tx_mem[mem_fill[ADDR_W-1:0]] = txb;
          mem_fill = mem_fill + 1'b1;
        end
        if (last) msg_ready = 1'b1;
      end
    end else if (idle) begin
      if (msg_ready) begin
        msg_ready = 1'b0;
        byte_pos  = '0;
        bit_pos   = '0;
        high_next = 1'b0;
        rx_acc    = '0;
        pin_cs    = 1'b0;
        pin_sck   = 1'b1;
        ph        = PH_SEND;
      end
    end else if (ph == PH_SEND) begin
      cur = tx_mem[byte_pos];
      pin_mosi = cur[3'd7 - bit_pos];
      if (!high_next) begin
        pin_sck   = 1'b0;
        high_next = 1'b1;
      end else begin
        pin_sck   = 1'b1;
        high_next = 1'b0;
        rx_acc    = {rx_acc[6:0], miso};
        if (bit_pos == 3'd7) begin
          bit_pos    = '0;
          r.rx_valid = 1'b1;
          r.rx_byte  = rx_acc;
          if (int'(byte_pos) + 1 >= int'(mem_fill)) begin
            r.rx_last = 1'b1;
            ph        = PH_END;
          end else begin
            byte_pos = byte_pos + 1'b1;
          end
        end else begin
          bit_pos = bit_pos + 1'b1;
        end
      end
    end else begin
      pin_cs    = 1'b1;
      pin_sck   = 1'b1;
      ph        = PH_IDLE;
      mem_fill  = '0;
      msg_ready = 1'b0;
      byte_pos  = '0;
      bit_pos   = '0;
      high_next = 1'b0;
    end
    r.cs   = pin_cs;
    r.sclk = pin_sck;
    r.mosi = pin_mosi;
    r.busy = (ph == PH_SEND) || (ph == PH_END);
    return r;
  endfunction

  // Called at a rising edge; returns once the word is taken, after any idle gap that follows.
  task automatic offer_word(kind_t op, logic [7:0] txb, logic last, logic miso,
                            logic typed, pin_word_t typed_want);
    pin_word_t want;
    in_valid     <= 1'b1;
    in_op        <= op;
    in_tx_byte   <= txb;
    in_load_last <= last;
    in_miso      <= miso;
    do @(posedge clk); while (!in_ready);
    want = predict_pins(op, txb, last, miso);
    pin_exp_q.push_back(typed ? typed_want : want);
    burst_left--;
    if (burst_left <= 0) begin
      burst_left = $urandom_range(1, 40);
      if ($urandom_range(0, 3) != 0) begin
        in_valid <= 1'b0;
        repeat ($urandom_range(1, 5)) @(posedge clk);
      end
    end
  endtask

  task automatic wait_drained();
    in_valid <= 1'b0;
    do @(posedge clk); while (pin_exp_q.size() != 0);
  endtask

  // Loads a message, then ticks until the transfer has ended. Noisy messages
  // add words that the block must ignore.
  task automatic run_message(int nbytes, bit noisy);
    if (noisy) begin
      offer_word(KIND_TICK, $urandom_range(0, 255), $urandom_range(0, 1),
                 $urandom_range(0, 1), 1'b0, NO_PINS);
    end
    for (int i = 0; i < nbytes; i++) begin
      offer_word(KIND_LOAD, $urandom_range(0, 255), (i == nbytes - 1),
                 $urandom_range(0, 1), 1'b0, NO_PINS);
      words_sent++;
    end
    if (noisy) begin
      offer_word(KIND_LOAD, $urandom_range(0, 255), $urandom_range(0, 1),
                 $urandom_range(0, 1), 1'b0, NO_PINS);
    end
    do begin
      if (noisy && ph != PH_IDLE && $urandom_range(0, 15) == 0) begin
        offer_word(KIND_LOAD, $urandom_range(0, 255), $urandom_range(0, 1),
                   $urandom_range(0, 1), 1'b0, NO_PINS);
      end else begin
        offer_word(KIND_TICK, $urandom_range(0, 255), $urandom_range(0, 1),
                   $urandom_range(0, 1), 1'b0, NO_PINS);
        words_sent++;
      end
    end while (ph != PH_IDLE);
  endtask

  initial begin : stimulus
    int pick;
    int nbytes;
    repeat (8) @(posedge clk);
    rst_n <= 1'b1;

    for (int r = 0; r < DIR_ROWS; r++) begin
      repeat (dir_tab[r].reps) begin
        offer_word(dir_tab[r].op, dir_tab[r].tx_byte, dir_tab[r].last, dir_tab[r].miso,
                   dir_tab[r].typed, dir_tab[r].want);
      end
    end
    wait_drained();

    while (words_sent < WORD_TARGET) begin
      pick = $urandom_range(0, 19);
      if (pick < 14) nbytes = $urandom_range(1, 3);
      else if (pick < 19) nbytes = $urandom_range(4, 8);
      else nbytes = $urandom_range(16, 32);
      run_message(nbytes, $urandom_range(0, 3) == 0);
    end
    wait_drained();

    repeat (DRAIN_WAIT) @(posedge clk);
    if (mismatches == 0) begin
      $display("Regression PASS");
    end else begin
      $display("Regression FAIL");
    end
    $finish;
  end

  initial begin : out_pacing
    int mode;
    int span;
    int cyc;
    bit held;
    cyc  = 0;
    held = 1'b0;
    forever begin
      mode = $urandom_range(0, 3);
      span = $urandom_range(16, 96);
      repeat (span) begin
        @(posedge clk);
        cyc++;
        case (mode)
          0: out_ready <= 1'b1;
          1: out_ready <= ($urandom_range(0, 1) == 1);
          2: out_ready <= ($urandom_range(0, 3) == 0);
          default: out_ready <= (cyc % 5 != 0);
        endcase
      end
      // One long hold-off, so that the block backs up into its input.
      if (!held && cyc >= HOLD_AT) begin
        held = 1'b1;
        @(posedge clk);
        out_ready <= 1'b0;
        repeat (HOLD_LEN) @(posedge clk);
      end
    end
  end

  task automatic check_field(string name, logic [7:0] want, logic [7:0] got);
    if (want !== got) begin
      $error("%s: expected %0h, got %0h", name, want, got);
      mismatches++;
    end
  endtask

  always @(posedge clk) begin : result_check
    pin_word_t want;
    if (rst_n) begin
      if ((in_valid && in_ready) || (out_valid && out_ready)) quiet_cycles = 0;
      else quiet_cycles++;
      if (quiet_cycles >= STALL_LIMIT) begin
        $display("Regression FAIL");
        $finish;
      end
      if (out_valid && out_ready) begin
        if (pin_exp_q.size() == 0) begin
          $error("result word arrived with no expectation pending");
          mismatches++;
        end else begin
          want = pin_exp_q.pop_front();
          check_field("chip_select", want.cs, out_chip_select);
          check_field("serial_clock", want.sclk, out_serial_clock);
          check_field("mosi", want.mosi, out_mosi);
          check_field("rx_valid", want.rx_valid, out_rx_valid);
          check_field("rx_byte", want.rx_byte, out_rx_byte);
          check_field("rx_last", want.rx_last, out_rx_last);
          check_field("busy_res", want.busy, out_busy_res);
        end
      end
    end
  end

endmodule
